// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define EMTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("emtc check failed: same-cycle property");

// consequent must hold in the cycle after the antecedent
`define EMTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("emtc check failed: next-cycle property");

`endif

// File: rtl/emtc_pkg.sv
// shared constants, types and functions of the elapsed-minutes calendar block
`default_nettype none

package emtc_pkg;

    // width of the minute count actually used
    localparam int MINUTE_BITS = 24;

    // fixed field widths
    localparam int IN_W    = 24;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HHMM_W  = 12;
    localparam int HOUR_W  = 6;
    localparam int MIN_W   = 6;

    // divider widths
    localparam int DIVISOR_W = 11;
    localparam int REM_W     = 11;
    localparam int DIV_STEPS = 2;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_START_MONTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_DAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_HHMM  = 2'd2;

    // calendar constants
    localparam logic [DIVISOR_W-1:0] MINS_PER_DAY  = 11'd1440;
    localparam logic [DIVISOR_W-1:0] MINS_PER_HOUR = 11'd60;
    localparam logic [DIVISOR_W-1:0] HHMM_SCALE    = 11'd100;
    localparam logic [DIVISOR_W-1:0] DAYS_PER_YEAR = 11'd365;
    localparam logic [HOUR_W-1:0]    HOURS_PER_DAY = 6'd24;
    localparam logic [MONTH_W-1:0]   MONTHS        = 4'd12;
    localparam logic [MONTH_W-1:0]   FIRST_MONTH   = 4'd1;

    // reciprocal divider: (x * recip) >> shift is exact for any x below 2**MINUTE_BITS
    // when shift is MINUTE_BITS plus the divisor's bit length and recip is rounded up
    localparam int RECIP_W     = MINUTE_BITS + 1;
    localparam int PROD_W      = MINUTE_BITS + RECIP_W;
    localparam int SHIFT_DAY   = MINUTE_BITS + $clog2(MINS_PER_DAY);
    localparam int SHIFT_HOUR  = MINUTE_BITS + $clog2(MINS_PER_HOUR);
    localparam int SHIFT_START = MINUTE_BITS + $clog2(HHMM_SCALE);
    localparam int SHIFT_YEAR  = MINUTE_BITS + $clog2(DAYS_PER_YEAR);

    localparam logic [RECIP_W-1:0] RECIP_DAY = RECIP_W'(
        ((64'd1 << SHIFT_DAY) + 64'(MINS_PER_DAY) - 64'd1) / 64'(MINS_PER_DAY));
    localparam logic [RECIP_W-1:0] RECIP_HOUR = RECIP_W'(
        ((64'd1 << SHIFT_HOUR) + 64'(MINS_PER_HOUR) - 64'd1) / 64'(MINS_PER_HOUR));
    localparam logic [RECIP_W-1:0] RECIP_START = RECIP_W'(
        ((64'd1 << SHIFT_START) + 64'(HHMM_SCALE) - 64'd1) / 64'(HHMM_SCALE));
    localparam logic [RECIP_W-1:0] RECIP_YEAR = RECIP_W'(
        ((64'd1 << SHIFT_YEAR) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));

    // operand select of the shared divider
    typedef enum logic [1:0] {
        SEL_DAY   = 2'd0,
        SEL_HOUR  = 2'd1,
        SEL_START = 2'd2,
        SEL_YEAR  = 2'd3
    } t_div_sel;

    // controller to datapath
    typedef struct packed {
        logic     div_start;
        t_div_sel div_sel;
        logic     div_capture;
        logic     combine;
        logic     walk_step;
        logic     out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic walk_done;
        logic out_busy;
    } t_dp_status;

    // non-leap month lengths
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // out-of-range start month maps to the nearest valid month
    function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] res;
        if (m == '0) begin
            res = FIRST_MONTH;
        end else if (m > MONTHS) begin
            res = MONTHS;
        end else begin
            res = m;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/emtc_if.sv
// stream interfaces for input, result and configuration channels
`default_nettype none

interface emtc_in_if;
    import emtc_pkg::*;
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] minute_count;

    modport source (output valid, output minute_count, input ready);
    modport sink   (input valid, input minute_count, output ready);
endinterface

interface emtc_out_if;
    import emtc_pkg::*;
    logic               valid;
    logic               ready;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HHMM_W-1:0]  clock_hhmm;

    modport source (output valid, output month, output day, output clock_hhmm, input ready);
    modport sink   (input valid, input month, input day, input clock_hhmm, output ready);
endinterface

interface emtc_cfg_if;
    import emtc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/emtc_ctrl.sv
// controller state machine sequencing the divider, month walk and output load
`default_nettype none

module emtc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  emtc_pkg::t_dp_status i_status,
    output emtc_pkg::t_dp_cmd    o_cmd
);
    import emtc_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DAY     = 9'b000000010,
        S_HOUR    = 9'b000000100,
        S_START   = 9'b000001000,
        S_COMBINE = 9'b000010000,
        S_YLOAD   = 9'b000100000,
        S_YEAR    = 9'b001000000,
        S_WALK    = 9'b010000000,
        S_OUT     = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = SEL_DAY;
                    n_state         = S_DAY;
                end
            end
            S_DAY: begin
                if (i_status.div_done) begin
                    o_cmd.div_capture = 1'b1;
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel     = SEL_HOUR;
                    n_state           = S_HOUR;
                end
            end
            S_HOUR: begin
                if (i_status.div_done) begin
                    o_cmd.div_capture = 1'b1;
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel     = SEL_START;
                    n_state           = S_START;
                end
            end
            S_START: begin
                if (i_status.div_done) begin
                    o_cmd.div_capture = 1'b1;
                    n_state           = S_COMBINE;
                end
            end
            S_COMBINE: begin
                o_cmd.combine = 1'b1;
                n_state       = S_YLOAD;
            end
            S_YLOAD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = SEL_YEAR;
                n_state         = S_YEAR;
            end
            S_YEAR: begin
                if (i_status.div_done) begin
                    o_cmd.div_capture = 1'b1;
                    n_state           = S_WALK;
                end
            end
            S_WALK: begin
                if (i_status.walk_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/emtc_dp.sv
// datapath: config registers, shared reciprocal divider, month walk, output register
`default_nettype none

module emtc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  emtc_pkg::t_dp_cmd               i_cmd,
    output emtc_pkg::t_dp_status            o_status,
    input  logic [emtc_pkg::IN_W-1:0]       i_minutes,
    input  logic                            i_cfg_valid,
    input  logic [emtc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [emtc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [emtc_pkg::MONTH_W-1:0]    o_month,
    output logic [emtc_pkg::DAY_W-1:0]      o_day,
    output logic [emtc_pkg::HHMM_W-1:0]     o_hhmm
);
    import emtc_pkg::*;

    localparam int HHMM_FULL_W = HHMM_W + 1;
    localparam logic [MINUTE_BITS-1:0] DAY_ONE = MINUTE_BITS'(1);

    // configuration
    logic [MONTH_W-1:0] r_cfg_month;
    logic [DAY_W-1:0]   r_cfg_day;
    logic [HHMM_W-1:0]  r_cfg_hhmm;

    // divider
    logic [MINUTE_BITS-1:0] r_num, n_num;
    logic [MINUTE_BITS-1:0] r_quo, n_quo;
    logic [REM_W-1:0]       r_rem, n_rem;
    logic [STEP_W-1:0]      r_cnt, n_cnt;
    t_div_sel               r_sel, n_sel;
    logic [MINUTE_BITS-1:0] w_dividend;
    logic [DIVISOR_W-1:0]   w_divisor;
    logic [RECIP_W-1:0]     w_recip;
    logic [PROD_W-1:0]      w_prod;
    logic [MINUTE_BITS-1:0] w_quo;
    logic [MINUTE_BITS-1:0] w_back;
    logic                   w_div_done;

    // working values
    logic [MINUTE_BITS-1:0] r_day, n_day;
    logic [HOUR_W-1:0]      r_hour, n_hour;
    logic [MIN_W-1:0]       r_minute, n_minute;
    logic [HOUR_W-1:0]      r_start_hour, n_start_hour;
    logic [MONTH_W-1:0]     r_month, n_month;
    logic [HOUR_W-1:0]      w_hour_sum;
    logic                   w_carry;
    logic [DAY_W-1:0]       w_len;
    logic                   w_walk_done;
    logic [HHMM_FULL_W-1:0] w_hhmm_full;

    // output register
    logic               r_out_valid;
    logic [MONTH_W-1:0] r_out_month;
    logic [DAY_W-1:0]   r_out_day;
    logic [HHMM_W-1:0]  r_out_hhmm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_month <= FIRST_MONTH;
            r_cfg_day   <= DAY_W'(1);
            r_cfg_hhmm  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_MONTH: r_cfg_month <= i_cfg_data[MONTH_W-1:0];
                REG_START_DAY:   r_cfg_day   <= i_cfg_data[DAY_W-1:0];
                REG_START_HHMM:  r_cfg_hhmm  <= i_cfg_data[HHMM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            SEL_DAY:   w_dividend = MINUTE_BITS'(i_minutes);
            SEL_HOUR:  w_dividend = MINUTE_BITS'(r_rem);
            SEL_START: w_dividend = MINUTE_BITS'(r_cfg_hhmm);
            SEL_YEAR:  w_dividend = r_day - DAY_ONE;
            default:   w_dividend = '0;
        endcase
    end

    always_comb begin
        case (r_sel)
            SEL_DAY: begin
                w_divisor = MINS_PER_DAY;
                w_recip   = RECIP_DAY;
            end
            SEL_HOUR: begin
                w_divisor = MINS_PER_HOUR;
                w_recip   = RECIP_HOUR;
            end
            SEL_START: begin
                w_divisor = HHMM_SCALE;
                w_recip   = RECIP_START;
            end
            SEL_YEAR: begin
                w_divisor = DAYS_PER_YEAR;
                w_recip   = RECIP_YEAR;
            end
            default: begin
                w_divisor = MINS_PER_DAY;
                w_recip   = RECIP_DAY;
            end
        endcase
    end

    // quotient by reciprocal multiply, remainder from it in the following cycle
    assign w_prod = PROD_W'(r_num) * PROD_W'(w_recip);

    always_comb begin
        case (r_sel)
            SEL_DAY:   w_quo = MINUTE_BITS'(w_prod >> SHIFT_DAY);
            SEL_HOUR:  w_quo = MINUTE_BITS'(w_prod >> SHIFT_HOUR);
            SEL_START: w_quo = MINUTE_BITS'(w_prod >> SHIFT_START);
            SEL_YEAR:  w_quo = MINUTE_BITS'(w_prod >> SHIFT_YEAR);
            default:   w_quo = MINUTE_BITS'(w_prod >> SHIFT_DAY);
        endcase
    end

    assign w_back     = r_quo * MINUTE_BITS'(w_divisor);
    assign w_div_done = (r_cnt == STEP_W'(DIV_STEPS));

    always_comb begin
        n_num = r_num;
        n_quo = r_quo;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_sel = r_sel;
        if (i_cmd.div_start) begin
            n_num = w_dividend;
            n_cnt = '0;
            n_sel = i_cmd.div_sel;
        end else if (!w_div_done) begin
            if (r_cnt == '0) begin
                n_quo = w_quo;
            end else begin
                n_rem = REM_W'(r_num - w_back);
            end
            n_cnt = r_cnt + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= STEP_W'(DIV_STEPS);
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_sel <= n_sel;
    end

    // hour carry and month walk
    assign w_hour_sum  = r_hour + r_start_hour;
    assign w_carry     = (w_hour_sum >= HOURS_PER_DAY);
    assign w_len       = month_len(r_month);
    assign w_walk_done = (r_day <= MINUTE_BITS'(w_len));

    always_comb begin
        n_day        = r_day;
        n_hour       = r_hour;
        n_minute     = r_minute;
        n_start_hour = r_start_hour;
        n_month      = r_month;
        if (i_cmd.div_capture) begin
            case (r_sel)
                SEL_DAY: begin
                    n_day = r_quo;
                end
                SEL_HOUR: begin
                    n_hour   = r_quo[HOUR_W-1:0];
                    n_minute = r_rem[MIN_W-1:0];
                end
                SEL_START: begin
                    n_start_hour = r_quo[HOUR_W-1:0];
                end
                SEL_YEAR: begin
                    if (r_day > MINUTE_BITS'(DAYS_PER_YEAR)) begin
                        n_day = MINUTE_BITS'(r_rem) + DAY_ONE;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.combine) begin
            n_hour  = w_carry ? (w_hour_sum - HOURS_PER_DAY) : w_hour_sum;
            n_day   = r_day + MINUTE_BITS'(w_carry) + MINUTE_BITS'(r_cfg_day);
            n_month = clamp_month(r_cfg_month);
        end else if (i_cmd.walk_step) begin
            n_day   = r_day - MINUTE_BITS'(w_len);
            n_month = (r_month == MONTHS) ? FIRST_MONTH : (r_month + MONTH_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_day        <= n_day;
        r_hour       <= n_hour;
        r_minute     <= n_minute;
        r_start_hour <= n_start_hour;
        r_month      <= n_month;
    end

    assign w_hhmm_full = HHMM_FULL_W'(r_hour) * HHMM_FULL_W'(HHMM_SCALE)
                       + HHMM_FULL_W'(r_minute);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_month <= r_month;
            r_out_day   <= r_day[DAY_W-1:0];
            r_out_hhmm  <= w_hhmm_full[HHMM_W-1:0];
        end
    end

    assign o_status.div_done  = w_div_done;
    assign o_status.walk_done = w_walk_done;
    assign o_status.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_month     = r_out_month;
    assign o_day       = r_out_day;
    assign o_hhmm      = r_out_hhmm;

endmodule

`default_nettype wire

// File: rtl/elapsed_minutes_to_calendar.sv
// one transaction at a time: four divider passes and the month walk run before the result is loaded;
// a stalled result register holds the sequencer in its output state until the held result is taken
// the reciprocal-multiply divider is shared by the day, hour, start-hour and year reductions
// a finished result waits in the output register; the next input is taken once it is loaded
// reset: synchronous active low; config returns to month 1, day 1, hhmm 0, no result pending
`default_nettype none

module elapsed_minutes_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    emtc_in_if.sink     i_in,
    emtc_out_if.source  o_res,
    emtc_cfg_if.sink    i_cfg
);
    import emtc_pkg::*;

    // command and status between the sequencer and the datapath
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    // config writes are always taken; software must write only while the block is idle, the block does not enforce it
    assign i_cfg.ready = 1'b1;

    // input side handshake: the sequencer takes a transaction only in its idle state
    assign i_in.ready = w_in_ready;

    // sequencer: day split, hour split, start hour, hour carry and day add,
    // year fold, then the month walk and the output load
    emtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath: holds the config registers, the shared divider, the working
    // day/hour/minute/month registers and the result register
    emtc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_minutes   (i_in.minute_count),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_month     (o_res.month),
        .o_day       (o_res.day),
        .o_hhmm      (o_res.clock_hhmm)
    );

endmodule

`default_nettype wire

// File: rtl/emtc_checker.sv
// port-level checker for the calendar block and its bind
`default_nettype none
`include "assert_macros.svh"

module emtc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [emtc_pkg::MONTH_W-1:0] i_month,
    input logic [emtc_pkg::DAY_W-1:0]   i_day,
    input logic [emtc_pkg::HHMM_W-1:0]  i_hhmm
);
    import emtc_pkg::*;

    // highest clock value: hour 39 after the single carry, minute 59
    localparam logic [HHMM_W-1:0] HHMM_MAX = 12'd3959;

    // a stalled result keeps its payload
    `EMTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_month) && $stable(i_day) && $stable(i_hhmm))

    // a transaction keeps the block busy in the following cycle
    `EMTC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // the month walk always lands on a real month
    `EMTC_ASSERT_NOW(a_month_range, i_clk, i_rst_n, i_out_valid, (i_month >= FIRST_MONTH) && (i_month <= MONTHS))

    // the clock never goes past one carry of the start hour
    `EMTC_ASSERT_NOW(a_hhmm_range, i_clk, i_rst_n, i_out_valid, i_hhmm <= HHMM_MAX)

endmodule

bind elapsed_minutes_to_calendar emtc_checker u_emtc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_month     (o_res.month),
    .i_day       (o_res.day),
    .i_hhmm      (o_res.clock_hhmm)
);

`default_nettype wire

// File: bench/elapsed_minutes_to_calendar_tb.sv
// self-checking testbench for the elapsed-minutes to month/day/hhmm converter
module elapsed_minutes_to_calendar_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import emtc_pkg::*;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HHMM_W-1:0]  clock_hhmm;
    } t_calendar;

    // non-leap month lengths, index 1 = january
    localparam int unsigned DAYS_IN_MONTH [1:12] = '{31, 28, 31, 30, 31, 30,
                                                     31, 31, 30, 31, 30, 31};
    localparam int unsigned MIN_PER_DAY  = 1440;
    localparam int unsigned MIN_PER_HOUR = 60;
    localparam int unsigned YEAR_DAYS    = 365;
    localparam int unsigned YEAR_MINUTES = 525600;
    localparam int unsigned DRAIN_CYCLES = 150;

    logic clk;
    logic rst_n;

    emtc_in_if  in_if ();
    emtc_out_if res_if ();
    emtc_cfg_if cfg_if ();

    elapsed_minutes_to_calendar u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // shadow copy of the start registers
    logic [MONTH_W-1:0] start_month_q;
    logic [DAY_W-1:0]   start_day_q;
    logic [HHMM_W-1:0]  start_hhmm_q;

    t_calendar expected_dates[$];
    int        error_count;

    // no random gaps on either side while set
    bit        idle_free;
    // receiver stall counters, both counted down at the falling edge
    int        result_stall_left;
    int        result_hold_left;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // converts a minute count with the current start registers
    function automatic t_calendar predict_calendar(input logic [IN_W-1:0] mins);
        longint unsigned total;
        int unsigned     days;
        int unsigned     rem;
        int unsigned     hour;
        int unsigned     minute;
        int unsigned     mon;
        int unsigned     step;
        t_calendar       res;
        total  = longint'(mins) & ((64'd1 << MINUTE_BITS) - 64'd1);
        days   = int'(total / MIN_PER_DAY);
        rem    = int'(total % MIN_PER_DAY);
        hour   = rem / MIN_PER_HOUR;
        minute = rem % MIN_PER_HOUR;
        // month register out of range snaps to january or december
        if (start_month_q == 0) begin
            mon = 1;
        end else if (start_month_q > 12) begin
            mon = 12;
        end else begin
            mon = start_month_q;
        end
        // start hour may exceed 23; only a single day carry is taken
        hour = hour + start_hhmm_q / 100;
        if (hour >= 24) begin
            hour = hour - 24;
            days = days + 1;
        end
        days = days + start_day_q;
        // strip whole years, then walk the months
        if (days > YEAR_DAYS) begin
            days = days - ((days - 1) / YEAR_DAYS) * YEAR_DAYS;
        end
        step = 0;
        while (step < 13 && days > DAYS_IN_MONTH[mon]) begin
            days = days - DAYS_IN_MONTH[mon];
            mon  = (mon == 12) ? 1 : mon + 1;
            step++;
        end
        res.month      = MONTH_W'(mon);
        res.day        = DAY_W'(days);
        res.clock_hhmm = HHMM_W'(hour * 100 + minute);
        return res;
    endfunction

    // mix of short spans, month walks, full-range counts and year edges
    function automatic logic [IN_W-1:0] rand_minutes();
        logic [IN_W-1:0] mins;
        int unsigned     years;
        case ($urandom_range(0, 3))
            0: mins = IN_W'($urandom_range(0, 2 * MIN_PER_DAY - 1));
            1: mins = IN_W'($urandom_range(0, 366 * MIN_PER_DAY));
            2: mins = IN_W'($urandom);
            default: begin
                years = $urandom_range(0, 31);
                mins  = IN_W'(years * YEAR_MINUTES + $urandom_range(0, 2 * MIN_PER_DAY - 1));
            end
        endcase
        return mins;
    endfunction

    // one input transaction; valid stays high when no gap follows
    task automatic send_minutes(input logic [IN_W-1:0] mins);
        int gap;
        gap = idle_free ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap != 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.minute_count = mins;
        in_if.valid        = 1'b1;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        expected_dates.push_back(predict_calendar(mins));
    endtask

    // drop the input and wait until every pending result is back
    task automatic wait_all_results();
        @(negedge clk);
        in_if.valid = 1'b0;
        while (expected_dates.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.index = idx;
        cfg_if.data  = value;
        cfg_if.valid = 1'b1;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        case (idx)
            REG_START_MONTH: start_month_q = value[MONTH_W-1:0];
            REG_START_DAY:   start_day_q   = value[DAY_W-1:0];
            REG_START_HHMM:  start_hhmm_q  = value[HHMM_W-1:0];
            default: ;
        endcase
    endtask

    // only called while the block is idle
    task automatic configure(input logic [CFG_DATA_W-1:0] month_val,
                             input logic [CFG_DATA_W-1:0] day_val,
                             input logic [CFG_DATA_W-1:0] hhmm_val);
        write_reg(REG_START_MONTH, month_val);
        write_reg(REG_START_DAY, day_val);
        write_reg(REG_START_HHMM, hhmm_val);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // reset values: january 1st, 00:00
    task automatic test_default_start();
        send_minutes('0);
        send_minutes(IN_W'(59));
        send_minutes(IN_W'(1439));
        send_minutes(IN_W'(1440));
        send_minutes('1);
        send_minutes(IN_W'(YEAR_MINUTES));
        wait_all_results();
    endtask

    // clamped months, start day of zero, start hour past 23, year wrap
    task automatic test_special_starts();
        // month 0 runs as january; start hour 23 carries on the first hour
        configure(12'd0, 12'd31, 12'd2359);
        send_minutes('0);
        send_minutes(IN_W'(60));
        send_minutes(IN_W'(24'h800000));
        wait_all_results();
        // month 15 runs as december; start day 0; hour 40 from the hhmm field
        configure(12'd15, 12'd0, 12'd4095);
        send_minutes('0);
        send_minutes(IN_W'(1439));
        send_minutes(IN_W'(30 * MIN_PER_DAY));
        wait_all_results();
        // december 31st rolls over into january
        configure(12'd12, 12'd31, 12'd0);
        send_minutes(IN_W'(MIN_PER_DAY));
        send_minutes(IN_W'(2 * YEAR_MINUTES + 59 * MIN_PER_DAY));
        wait_all_results();
        // noon on february 28th plus twelve hours lands on march 1st
        configure(12'd2, 12'd28, 12'd1200);
        send_minutes(IN_W'(720));
        wait_all_results();
        configure(12'd13, 12'd1, 12'd0);
        send_minutes('0);
        wait_all_results();
    endtask

    // random starts and counts, some phases without idle cycles
    task automatic test_random_traffic();
        for (int phase = 0; phase < 12; phase++) begin
            if (phase % 3 == 0) begin
                // raw register data, upper bits included
                configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom));
            end else begin
                configure(CFG_DATA_W'($urandom_range(1, 12)),
                          CFG_DATA_W'($urandom_range(1, 31)),
                          CFG_DATA_W'($urandom_range(0, 23) * 100 + $urandom_range(0, 59)));
            end
            idle_free = (phase % 4 == 3);
            repeat (50) send_minutes(rand_minutes());
            wait_all_results();
            idle_free = 1'b0;
        end
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        @(posedge clk);
        result_hold_left = 400;
        idle_free        = 1'b1;
        repeat (8) send_minutes(rand_minutes());
        wait_all_results();
        idle_free = 1'b0;
    endtask

    // sender waits for the block to empty between two bursts
    task automatic test_sender_pause();
        repeat (5) send_minutes(rand_minutes());
        wait_all_results();
        repeat (5) send_minutes(rand_minutes());
        wait_all_results();
    endtask

    // result ready, driven at the falling edge
    always @(negedge clk) begin
        if (result_hold_left != 0) begin
            res_if.ready = 1'b0;
            result_hold_left--;
        end else if (result_stall_left != 0) begin
            res_if.ready = 1'b0;
            result_stall_left--;
        end else begin
            res_if.ready = 1'b1;
        end
    end

    // compare every result transaction against the oldest prediction
    always @(posedge clk) begin
        t_calendar want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (expected_dates.size() == 0) begin
                $error("result transaction with nothing expected: month %0d day %0d hhmm %0d",
                       res_if.month, res_if.day, res_if.clock_hhmm);
                error_count++;
            end else begin
                want = expected_dates.pop_front();
                if (res_if.month !== want.month) begin
                    $error("month: expected %0d, got %0d", want.month, res_if.month);
                    error_count++;
                end
                if (res_if.day !== want.day) begin
                    $error("day: expected %0d, got %0d", want.day, res_if.day);
                    error_count++;
                end
                if (res_if.clock_hhmm !== want.clock_hhmm) begin
                    $error("clock_hhmm: expected %0d, got %0d",
                           want.clock_hhmm, res_if.clock_hhmm);
                    error_count++;
                end
            end
            result_stall_left = idle_free ? 0 : $urandom_range(0, 4);
        end
    end

    initial begin
        rst_n              = 1'b0;
        in_if.valid        = 1'b0;
        in_if.minute_count = '0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_START_MONTH;
        cfg_if.data        = '0;
        start_month_q      = 4'd1;
        start_day_q        = 5'd1;
        start_hhmm_q       = '0;
        error_count        = 0;
        idle_free          = 1'b0;
        result_stall_left  = 0;
        result_hold_left   = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_start();
        test_special_starts();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();

        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("PASS elapsed_minutes_to_calendar");
        end else begin
            $display("FAIL elapsed_minutes_to_calendar");
        end
        $finish;
    end

    // time limit that ends a hung run as a failure
    initial begin
        #5_000_000;
        $display("FAIL elapsed_minutes_to_calendar");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/emtc_pkg.sv
rtl/emtc_if.sv
rtl/emtc_ctrl.sv
rtl/emtc_dp.sv
rtl/elapsed_minutes_to_calendar.sv
rtl/emtc_checker.sv
bench/elapsed_minutes_to_calendar_tb.sv
